@@ hdl/life_pkg.sv @@
// Shared types and constants for the Life row-step automaton.
package life_pkg;

   localparam int ROW_BITS   = 64;
   localparam int RULE_W     = 4;
   localparam int WIDTH_W    = 7;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Neighbor-count limits of the survival and birth rules.
   typedef struct packed {
      logic [RULE_W-1:0] survive_min;
      logic [RULE_W-1:0] survive_max;
      logic [RULE_W-1:0] birth_min;
      logic [RULE_W-1:0] birth_max;
   } life_rule_type;

   // One queued result transaction.
   typedef struct packed {
      logic [ROW_BITS-1:0] next_row;
      logic                last_of_frame;
   } life_rsp_type;

endpackage

@@ hdl/life_csr.sv @@
// Configuration registers for the Life row-step automaton, APB-style access.
module life_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [life_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [life_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [life_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output life_pkg::life_rule_type           rule,
   output logic [life_pkg::WIDTH_W-1:0]      active_width
);
   import life_pkg::*;

   localparam logic [2:0] REG_SURVIVE_MIN  = 3'd0;
   localparam logic [2:0] REG_SURVIVE_MAX  = 3'd1;
   localparam logic [2:0] REG_BIRTH_MIN    = 3'd2;
   localparam logic [2:0] REG_BIRTH_MAX    = 3'd3;
   localparam logic [2:0] REG_ACTIVE_WIDTH = 3'd4;

   life_rule_type       rule_ff, rule_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [2:0]          reg_index;
   logic                wr_en;

   assign reg_index = paddr[4:2];
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_comb begin
      rule_in  = rule_ff;
      width_in = width_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_SURVIVE_MIN:  rule_in.survive_min = pwdata[RULE_W-1:0];
            REG_SURVIVE_MAX:  rule_in.survive_max = pwdata[RULE_W-1:0];
            REG_BIRTH_MIN:    rule_in.birth_min   = pwdata[RULE_W-1:0];
            REG_BIRTH_MAX:    rule_in.birth_max   = pwdata[RULE_W-1:0];
            REG_ACTIVE_WIDTH: width_in            = pwdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SURVIVE_MIN:  prdata = CSR_DATA_W'(rule_ff.survive_min);
         REG_SURVIVE_MAX:  prdata = CSR_DATA_W'(rule_ff.survive_max);
         REG_BIRTH_MIN:    prdata = CSR_DATA_W'(rule_ff.birth_min);
         REG_BIRTH_MAX:    prdata = CSR_DATA_W'(rule_ff.birth_max);
         REG_ACTIVE_WIDTH: prdata = CSR_DATA_W'(width_ff);
         default:          prdata = '0;
      endcase
   end

   // Reset to the classic B3/S23 rule over the full row.
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff.survive_min <= RULE_W'(2);
         rule_ff.survive_max <= RULE_W'(3);
         rule_ff.birth_min   <= RULE_W'(3);
         rule_ff.birth_max   <= RULE_W'(3);
         width_ff            <= WIDTH_W'(64);
      end else begin
         rule_ff  <= rule_in;
         width_ff <= width_in;
      end
   end

   assign rule         = rule_ff;
   assign active_width = width_ff;

endmodule

@@ hdl/life_rule_eval.sv @@
// Next-generation evaluation of one row from its upper and lower neighbor rows.
module life_rule_eval #(
   parameter int CELLS = 64
) (
   input  logic [CELLS-1:0]        above_row,
   input  logic [CELLS-1:0]        here_row,
   input  logic [CELLS-1:0]        below_row,
   input  logic [CELLS-1:0]        mask,
   input  life_pkg::life_rule_type rule,
   output logic [CELLS-1:0]        next_cells
);
   import life_pkg::*;

   // Padded with a dead cell at each end so edge cells see dead neighbors.
   logic [CELLS+1:0] above_pad;
   logic [CELLS+1:0] here_pad;
   logic [CELLS+1:0] below_pad;

   assign above_pad = {1'b0, above_row & mask, 1'b0};
   assign here_pad  = {1'b0, here_row & mask, 1'b0};
   assign below_pad = {1'b0, below_row & mask, 1'b0};

   for (genvar c = 0; c < CELLS; c++) begin : g_cell
      logic [RULE_W-1:0] count;
      logic              lives;

      assign count = RULE_W'(above_pad[c]) + RULE_W'(above_pad[c+1])
                   + RULE_W'(above_pad[c+2]) + RULE_W'(here_pad[c])
                   + RULE_W'(here_pad[c+2]) + RULE_W'(below_pad[c])
                   + RULE_W'(below_pad[c+1]) + RULE_W'(below_pad[c+2]);

      assign lives = here_pad[c+1]
                   ? (count >= rule.survive_min) && (count <= rule.survive_max)
                   : (count >= rule.birth_min) && (count <= rule.birth_max);

      assign next_cells[c] = lives & mask[c];
   end

endmodule

@@ hdl/life_rsp_fifo.sv @@
// Four-entry result queue taking up to two results per cycle, one out per cycle.
module life_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push0,
   input  logic                   push1,
   input  life_pkg::life_rsp_type data0,
   input  life_pkg::life_rsp_type data1,
   input  logic                   pop,
   output logic                   room2,
   output logic                   not_empty,
   output life_pkg::life_rsp_type head
);
   import life_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   life_rsp_type       entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_ptr_next;
   logic [CNT_W-1:0]   push_cnt;
   logic               pop_ok;

   assign pop_ok      = pop & (count_ff != '0);
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign push_cnt    = CNT_W'(push0) + CNT_W'(push1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop_ok);
      count_in  = count_ff + push_cnt - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         entry_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         entry_ff[wr_ptr_next] <= data1;
      end
   end

   // Room check ignores a same-cycle pop to keep the stall path short.
   assign room2     = count_ff <= CNT_W'(DEPTH - 2);
   assign not_empty = count_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];

endmodule

@@ hdl/life_automaton_row_step.sv @@
// Top level of the Life row-step automaton: input register, row store and result queue.
//
// Rows of one grid stream in on the req_ channel, one transaction per row, bit i
// being column i. The row marked req_frame_end closes the grid. The rsp_ channel
// returns the next generation one row behind the input: a first row that is not
// closing gives no result, each later row the previous row's result, and the
// closing row gives the pending row's, if any, then its own, marked rsp_last_of_frame.
// A row is taken into the input register and evaluated against the two stored rows
// once the queue has room for two results; its results are written into the queue
// and offered on rsp_ from the head of the queue. One row is accepted
// every cycle while the receiver keeps up; a closing row with a pending row
// puts two results in the queue, which drain at one per cycle.
// When rsp_stall is held, the four-entry result queue fills and req_stall rises
// once fewer than two entries are free; nothing is lost.
// Reset empties the row store, the input register and the queue, and loads the
// B3/S23 rule with all columns active. Rule and width registers sit on the APB port;
// the user must write them only while no row is in flight; the block does not check.
module life_automaton_row_step #(
   parameter int ROW_CELLS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [life_pkg::ROW_BITS-1:0]     req_row_cells,
   input  logic                              req_frame_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [life_pkg::ROW_BITS-1:0]     rsp_next_row,
   output logic                              rsp_last_of_frame,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [life_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [life_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [life_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import life_pkg::*;

   life_rule_type         rule;
   logic [WIDTH_W-1:0]    active_width;
   logic [ROW_CELLS-1:0]  mask;

   logic                  in_vld_ff, in_vld_in;
   logic [ROW_CELLS-1:0]  in_row_ff, in_row_in;
   logic                  in_last_ff, in_last_in;

   logic [ROW_CELLS-1:0]  upper_ff, upper_in;
   logic [ROW_CELLS-1:0]  middle_ff, middle_in;
   logic                  mid_vld_ff, mid_vld_in;

   logic [ROW_CELLS-1:0]  row_masked;
   logic [ROW_CELLS-1:0]  pend_cells;
   logic [ROW_CELLS-1:0]  last_cells;
   logic [ROW_CELLS-1:0]  dead_row;
   logic [ROW_BITS-1:0]   pend_wide;
   logic [ROW_BITS-1:0]   last_wide;

   logic                  accept;
   logic                  fire;
   logic                  room2;
   logic                  rsp_pop;
   logic                  push0;
   logic                  push1;
   life_rsp_type          data0;
   life_rsp_type          data1;
   life_rsp_type          head;

   life_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .rule         (rule),
      .active_width (active_width)
   );

   // Columns at or beyond the active width are dead; widths past the row saturate.
   for (genvar i = 0; i < ROW_CELLS; i++) begin : g_mask
      assign mask[i] = WIDTH_W'(i) < active_width;
   end

   assign dead_row   = '0;
   assign row_masked = in_row_ff & mask;

   assign fire      = in_vld_ff & room2;
   assign req_stall = in_vld_ff & ~room2;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_row_in  = in_row_ff;
      in_last_in = in_last_ff;
      if (accept) begin
         in_vld_in  = 1'b1;
         in_row_in  = req_row_cells[ROW_CELLS-1:0];
         in_last_in = req_frame_end;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   // The middle row is kept at zero whenever no row is pending, so it serves
   // directly as the upper neighbor of the current row.
   always_comb begin
      upper_in   = upper_ff;
      middle_in  = middle_ff;
      mid_vld_in = mid_vld_ff;
      if (fire) begin
         if (in_last_ff) begin
            upper_in   = '0;
            middle_in  = '0;
            mid_vld_in = 1'b0;
         end else begin
            upper_in   = middle_ff;
            middle_in  = row_masked;
            mid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         upper_ff   <= '0;
         middle_ff  <= '0;
         mid_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         upper_ff   <= upper_in;
         middle_ff  <= middle_in;
         mid_vld_ff <= mid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_row_ff  <= in_row_in;
      in_last_ff <= in_last_in;
   end

   life_rule_eval #(
      .CELLS (ROW_CELLS)
   ) u_eval_pend (
      .above_row  (upper_ff),
      .here_row   (middle_ff),
      .below_row  (row_masked),
      .mask       (mask),
      .rule       (rule),
      .next_cells (pend_cells)
   );

   life_rule_eval #(
      .CELLS (ROW_CELLS)
   ) u_eval_last (
      .above_row  (middle_ff),
      .here_row   (row_masked),
      .below_row  (dead_row),
      .mask       (mask),
      .rule       (rule),
      .next_cells (last_cells)
   );

   always_comb begin
      pend_wide                = '0;
      pend_wide[ROW_CELLS-1:0] = pend_cells;
      last_wide                = '0;
      last_wide[ROW_CELLS-1:0] = last_cells;
   end

   // The pending row's result, when present, goes ahead of the closing row's.
   always_comb begin
      push0               = fire & (mid_vld_ff | in_last_ff);
      push1               = fire & mid_vld_ff & in_last_ff;
      data1.next_row      = last_wide;
      data1.last_of_frame = 1'b1;
      if (mid_vld_ff) begin
         data0.next_row      = pend_wide;
         data0.last_of_frame = 1'b0;
      end else begin
         data0 = data1;
      end
   end

   assign rsp_pop = rsp_valid & ~rsp_stall;

   life_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .data0     (data0),
      .data1     (data1),
      .pop       (rsp_pop),
      .room2     (room2),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_next_row      = head.next_row;
   assign rsp_last_of_frame = head.last_of_frame;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the Life row-step automaton, with its own generation predictor.
module tb_top;
   import life_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;

   // Register indexes on the configuration port.
   localparam int CSR_SURVIVE_MIN  = 0;
   localparam int CSR_SURVIVE_MAX  = 1;
   localparam int CSR_BIRTH_MIN    = 2;
   localparam int CSR_BIRTH_MAX    = 3;
   localparam int CSR_ACTIVE_WIDTH = 4;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} stall_style_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ROW_BITS-1:0]    req_row_cells = '0;
   logic                   req_frame_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ROW_BITS-1:0]    rsp_next_row;
   logic                   rsp_last_of_frame;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr = '0;
   logic [CSR_DATA_W-1:0]  pwdata = '0;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   // Predictor copy of the rule, the width and the stored rows.
   logic [RULE_W-1:0]      rule_survive_min = 4'd2;
   logic [RULE_W-1:0]      rule_survive_max = 4'd3;
   logic [RULE_W-1:0]      rule_birth_min = 4'd3;
   logic [RULE_W-1:0]      rule_birth_max = 4'd3;
   logic [WIDTH_W-1:0]     cols_in_use = 7'd64;
   logic [ROW_BITS-1:0]    row_above = '0;
   logic [ROW_BITS-1:0]    row_pending = '0;
   logic                   pending_present = 1'b0;

   life_rsp_type           expected_gens[$];
   int                     error_count = 0;
   int                     cycle_count = 0;
   int                     burst_left = 0;
   bit                     sender_active = 1'b0;
   stall_style_type        stall_style = STALL_NONE;
   int                     stall_run = 0;

   life_automaton_row_step dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_row_cells(req_row_cells), .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_next_row(rsp_next_row), .rsp_last_of_frame(rsp_last_of_frame),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** life_automaton_row_step: FAILED **");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] expected,
                                  input logic [63:0] actual);
      $display("MISMATCH %s: expected %h, got %h (cycle %0d)", what, expected, actual,
               cycle_count);
      error_count++;
   endtask

   function automatic logic [ROW_BITS-1:0] width_mask();
      int w;
      w = int'(cols_in_use);
      if (w > ROW_BITS) w = ROW_BITS;
      if (w >= 64) return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   function automatic int cell_at(input logic [ROW_BITS-1:0] cells, input int col);
      if (col < 0 || col > ROW_BITS - 1) return 0;
      return int'(cells[col]);
   endfunction

   function automatic logic [ROW_BITS-1:0] evolve_row(input logic [ROW_BITS-1:0] above,
                                                      input logic [ROW_BITS-1:0] here,
                                                      input logic [ROW_BITS-1:0] below);
      logic [ROW_BITS-1:0] mask;
      logic [ROW_BITS-1:0] gen;
      int n;
      bit lives;
      mask = width_mask();
      above &= mask;
      here &= mask;
      below &= mask;
      gen = '0;
      for (int c = 0; c < ROW_BITS; c++) begin
         n = cell_at(above, c - 1) + cell_at(above, c) + cell_at(above, c + 1)
           + cell_at(here, c - 1) + cell_at(here, c + 1)
           + cell_at(below, c - 1) + cell_at(below, c) + cell_at(below, c + 1);
         if (here[c])
            lives = (n >= int'(rule_survive_min)) && (n <= int'(rule_survive_max));
         else
            lives = (n >= int'(rule_birth_min)) && (n <= int'(rule_birth_max));
         gen[c] = lives;
      end
      return gen & mask;
   endfunction

   // Works out the results that one accepted row causes and updates the row store.
   function automatic void predict_generation(input logic [ROW_BITS-1:0] cells,
                                              input logic frame_end);
      logic [ROW_BITS-1:0] row;
      logic [ROW_BITS-1:0] new_above;
      row = cells & width_mask();
      new_above = pending_present ? row_pending : '0;
      if (pending_present)
         expected_gens.push_back(life_rsp_type'{next_row: evolve_row(row_above, row_pending,
                                                                     row),
                                                last_of_frame: 1'b0});
      if (frame_end) begin
         expected_gens.push_back(life_rsp_type'{next_row: evolve_row(new_above, row, '0),
                                                last_of_frame: 1'b1});
         row_above = '0;
         row_pending = '0;
         pending_present = 1'b0;
      end else begin
         row_above = new_above;
         row_pending = row;
         pending_present = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_gens.size() == 0) begin
            report_mismatch("unexpected result transaction", '0, rsp_next_row);
         end else begin
            if (rsp_next_row !== expected_gens[0].next_row)
               report_mismatch("next_row", expected_gens[0].next_row, rsp_next_row);
            if (rsp_last_of_frame !== expected_gens[0].last_of_frame)
               report_mismatch("last_of_frame", 64'(expected_gens[0].last_of_frame),
                               64'(rsp_last_of_frame));
            void'(expected_gens.pop_front());
         end
      end
   end

   // The receiver switches between free running, random stalls and solid stalls.
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_run == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            stall_run = (stall_style == STALL_SOLID) ? $urandom_range(1, 16)
                                                     : $urandom_range(4, 60);
         end
         stall_run--;
         case (stall_style)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= 1'b1;
            end
         endcase
      end
   end

   // All tasks below start and end just after a falling clock edge.
   task automatic csr_write(input int idx, input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(idx * 4);
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         CSR_SURVIVE_MIN:  rule_survive_min = value[RULE_W-1:0];
         CSR_SURVIVE_MAX:  rule_survive_max = value[RULE_W-1:0];
         CSR_BIRTH_MIN:    rule_birth_min = value[RULE_W-1:0];
         CSR_BIRTH_MAX:    rule_birth_max = value[RULE_W-1:0];
         CSR_ACTIVE_WIDTH: cols_in_use = value[WIDTH_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_check(input int idx, input logic [CSR_DATA_W-1:0] expected);
      logic [CSR_DATA_W-1:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CSR_ADDR_W'(idx * 4);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== expected)
         report_mismatch($sformatf("register %0d read", idx), 64'(expected), 64'(got));
      @(negedge clock);
   endtask

   task automatic lower_valid();
      if (sender_active) begin
         req_valid <= 1'b0;
         sender_active = 1'b0;
      end
   endtask

   // Offers one row transaction, waits for it to be taken, then paces the next one.
   task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic frame_end);
      req_valid <= 1'b1;
      req_row_cells <= cells;
      req_frame_end <= frame_end;
      sender_active = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_generation(cells, frame_end);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         lower_valid();
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = $urandom_range(0, 40);
      end
   endtask

   task automatic pause_until_drained();
      lower_valid();
      while (expected_gens.size() != 0) @(negedge clock);
   endtask

   // A row with no result may still be in the pipeline once the queue is empty.
   task automatic settle_block();
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_rules(input int s_min, input int s_max, input int b_min,
                            input int b_max, input int cols);
      settle_block();
      csr_write(CSR_SURVIVE_MIN, s_min);
      csr_write(CSR_SURVIVE_MAX, s_max);
      csr_write(CSR_BIRTH_MIN, b_min);
      csr_write(CSR_BIRTH_MAX, b_max);
      csr_write(CSR_ACTIVE_WIDTH, cols);
   endtask

   function automatic logic [ROW_BITS-1:0] random_row();
      logic [ROW_BITS-1:0] a;
      logic [ROW_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return a & b & {$urandom, $urandom};
         3: return a | b;
         default: return a;
      endcase
   endfunction

   task automatic test_register_access();
      csr_check(CSR_SURVIVE_MIN, 2);
      csr_check(CSR_SURVIVE_MAX, 3);
      csr_check(CSR_BIRTH_MIN, 3);
      csr_check(CSR_BIRTH_MAX, 3);
      csr_check(CSR_ACTIVE_WIDTH, 64);
      csr_write(CSR_SURVIVE_MIN, 15);
      csr_check(CSR_SURVIVE_MIN, 15);
      csr_write(CSR_SURVIVE_MAX, 0);
      csr_check(CSR_SURVIVE_MAX, 0);
      csr_write(CSR_BIRTH_MIN, 10);
      csr_check(CSR_BIRTH_MIN, 10);
      csr_write(CSR_BIRTH_MAX, 5);
      csr_check(CSR_BIRTH_MAX, 5);
      csr_write(CSR_ACTIVE_WIDTH, 127);
      csr_check(CSR_ACTIVE_WIDTH, 127);
      csr_write(CSR_ACTIVE_WIDTH, 0);
      csr_check(CSR_ACTIVE_WIDTH, 0);
   endtask

   task automatic test_directed_rows();
      set_rules(2, 3, 3, 3, 64);
      // A grid of a single row sees dead rows above and below.
      send_row('1, 1'b1);
      // Edge columns wrap to nothing, so column 0 and column 63 see fewer neighbors.
      send_row(64'h8000_0000_0000_0003, 1'b0);
      send_row(64'hC000_0000_0000_0001, 1'b1);
      // A vertical blinker turns horizontal in its middle row.
      send_row(64'h0000_0000_0000_0008, 1'b0);
      send_row(64'h0000_0000_0000_0008, 1'b0);
      send_row(64'h0000_0000_0000_0008, 1'b1);
      send_row(64'h5555_5555_5555_5555, 1'b0);
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      // The pending row must survive a pause in the middle of a grid.
      pause_until_drained();
      send_row('1, 1'b0);
      send_row('0, 1'b1);
      // With no active columns every output row is zero.
      set_rules(2, 3, 3, 3, 0);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      // A width beyond the row saturates to the full row.
      set_rules(2, 3, 3, 3, 127);
      send_row(64'hF0F0_0F0F_FF00_00FF, 1'b0);
      send_row(64'h0FF0_F00F_0000_FFFF, 1'b1);
      set_rules(2, 3, 3, 3, 1);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      // An empty survival range kills every live cell.
      set_rules(5, 2, 0, 8, 3);
      send_row('1, 1'b0);
      send_row(64'hFFFF_FFFF_FFFF_FFFA, 1'b0);
      send_row('1, 1'b1);
      // Birth with zero neighbors fills a dead grid.
      set_rules(0, 0, 0, 0, 64);
      send_row('0, 1'b0);
      send_row('0, 1'b1);
   endtask

   task automatic test_random_frames();
      int sent;
      int height;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: set_rules(2, 3, 3, 3, 64);
            1: set_rules(0, 0, 0, 0, 64);
            2: set_rules(15, 15, 15, 15, 64);
            3: set_rules(0, 15, 0, 15, 1);
            4: set_rules(0, 8, 1, 8, 63);
            5: set_rules(8, 8, 8, 8, 127);
            6: set_rules(5, 2, 3, 3, 0);
            7: set_rules(2, 3, 3, 6, 65);
            default: set_rules($urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 15),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                           : $urandom_range(3, 64));
         endcase
         sent = 0;
         while (sent < 115) begin
            height = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 6);
            for (int r = 0; r < height; r++) begin
               send_row(random_row(), r == height - 1);
               sent++;
               if ($urandom_range(0, 59) == 0) pause_until_drained();
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_register_access();
      test_directed_rows();
      test_random_frames();
      pause_until_drained();
      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("** life_automaton_row_step: PASSED **");
      else
         $display("** life_automaton_row_step: FAILED **");
      $finish;
   end

endmodule
